/* hw/rtl/ppk_pkg.sv */
`timescale 1ns / 1ps

package ppk_pkg;

  localparam int COORD_W    = 14;
  localparam int STEP_W     = 16;
  localparam int SPU_W      = 24;
  localparam int RELOAD_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int STEP_BITS_DEF      = 16;
  localparam int SQRT_FRAC_BITS_DEF = 8;

  localparam logic [COORD_W-1:0]  BOARD_WIDTH_RST   = 14'd2500;
  localparam logic [SPU_W-1:0]    SPU_RST           = 24'd1668861;
  localparam logic [RELOAD_W-1:0] FAST_RELOAD_RST   = 16'hF03C;
  localparam logic [RELOAD_W-1:0] BASE_INTERVAL_RST = 16'h0FC3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOARD_WIDTH   = 3'd0,
    CFG_STEPS_PER_UNIT = 3'd1,
    CFG_FAST_RELOAD   = 3'd2,
    CFG_BASE_INTERVAL = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
  } ppk_in_t;

  typedef struct packed {
    logic [STEP_W-1:0]   left_steps;
    logic [STEP_W-1:0]   right_steps;
    logic [RELOAD_W-1:0] left_reload;
    logic [RELOAD_W-1:0] right_reload;
    logic                reload_valid;
    logic                saturated;
  } ppk_out_t;

endpackage

/* hw/rtl/polar_plotter_kinematics.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake             Payload
// in        in   in_valid_i/in_stall_o  in_req_i  (kind, x_coord, y_coord)
// out       out  out_valid_o/out_stall_i out_res_o (steps, reloads, flags)
// cfg       in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One request at a time through a shared multiplier and a shared subtractor.
// Per cable: two squares, a radicand load, ROOT_W root steps, scale and clamp
// (ROOT_W = 23 at defaults). A start point then takes a difference and a pick,
// as does an end point that needs no divide; one that does also runs a reload
// multiply and the 32-step restoring divide.
// Reset clears the sequencer, the output valid and the stored start targets; no sweep.
// A stalled result holds in the output register; the next request is taken once the
// sequencer has handed its result over.
module polar_plotter_kinematics #(
  parameter int STEP_BITS      = ppk_pkg::STEP_BITS_DEF,
  parameter int SQRT_FRAC_BITS = ppk_pkg::SQRT_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  ppk_pkg::ppk_in_t                 in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output ppk_pkg::ppk_out_t                out_res_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ppk_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ppk_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import ppk_pkg::*;

  localparam int SQ_W     = 2 * COORD_W;
  localparam int RAD_W    = SQ_W + 1 + 2 * SQRT_FRAC_BITS;
  localparam int ROOT_W   = (RAD_W + 1) / 2;
  localparam int SUB_W    = ROOT_W + 2;
  localparam int MUL_W    = ROOT_W + SPU_W;
  localparam int SHIFT    = SQRT_FRAC_BITS + 16;
  localparam int SH_W     = MUL_W - SHIFT;
  localparam int LIM_W    = (STEP_BITS < STEP_W) ? STEP_BITS : STEP_W;
  localparam int DIV_W    = 2 * RELOAD_W;
  localparam int ITER_MAX = (ROOT_W > DIV_W) ? ROOT_W : DIV_W;
  localparam int CNT_W    = $clog2(ITER_MAX);

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_RAD, S_SQRT, S_SCALE, S_CLAMP,
    S_DIFF, S_PICK, S_MULR, S_DLOAD, S_DIV, S_RFIN, S_DONE
  } state_e;

  state_e state_q;

  logic [COORD_W-1:0]  board_width_q;
  logic [SPU_W-1:0]    spu_q;
  logic [RELOAD_W-1:0] fast_reload_q;
  logic [RELOAD_W-1:0] base_interval_q;

  logic [STEP_W-1:0]   start_l_q, start_r_q;

  logic                kind_q, side_q, sat_q, slow_left_q;
  logic [COORD_W-1:0]  x_q, y_q;
  logic [SQ_W-1:0]     sq_q;
  logic [MUL_W-1:0]    mul_q;
  logic [2*ROOT_W-1:0] rad_q;
  logic [ROOT_W-1:0]   root_q;
  logic [SUB_W-1:0]    rem_q;
  logic [DIV_W-1:0]    div_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [STEP_W-1:0]   lt_q, rt_q, dl_q, dr_q, long_q, short_q;
  logic [RELOAD_W-1:0] lr_q, rr_q;
  logic                out_valid_q;
  ppk_out_t            out_q;

  // horizontal distance of the current cable
  logic [COORD_W:0]   dx_r;
  logic [COORD_W-1:0] adx;

  always_comb begin
    dx_r = {1'b0, board_width_q} - {1'b0, x_q};
    if (!side_q) begin
      adx = x_q;
    end else if (dx_r[COORD_W]) begin
      adx = COORD_W'(-dx_r);
    end else begin
      adx = dx_r[COORD_W-1:0];
    end
  end

  // shared multiplier
  logic [ROOT_W-1:0] mul_a;
  logic [SPU_W-1:0]  mul_b;
  logic [MUL_W-1:0]  mul_p;

  always_comb begin
    case (state_q)
      S_SQY: begin
        mul_a = ROOT_W'(y_q);
        mul_b = SPU_W'(y_q);
      end
      S_SCALE: begin
        mul_a = root_q;
        mul_b = spu_q;
      end
      S_MULR: begin
        mul_a = ROOT_W'(long_q);
        mul_b = SPU_W'(base_interval_q);
      end
      default: begin
        mul_a = ROOT_W'(adx);
        mul_b = SPU_W'(adx);
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // shared compare and subtract: root digits and quotient bits
  logic [SUB_W-1:0] sub_cand, sub_trial, sub_diff;
  logic [SUB_W:0]   sub_full;
  logic             sub_ge;

  always_comb begin
    if (state_q == S_DIV) begin
      sub_cand  = SUB_W'({rem_q[RELOAD_W-1:0], div_q[DIV_W-1]});
      sub_trial = SUB_W'(short_q);
    end else begin
      sub_cand  = {rem_q[SUB_W-3:0], rad_q[2*ROOT_W-1 -: 2]};
      sub_trial = {root_q, 2'b01};
    end
    sub_full = {1'b0, sub_cand} - {1'b0, sub_trial};
    sub_ge   = ~sub_full[SUB_W];
    sub_diff = sub_full[SUB_W-1:0];
  end

  // scale result and clamp
  logic [SH_W-1:0]   scaled;
  logic              over;
  logic [STEP_W-1:0] steps;
  logic [SQ_W:0]     sq_sum;

  always_comb begin
    scaled = mul_q[MUL_W-1:SHIFT];
    over   = |scaled[SH_W-1:LIM_W];
    steps  = over ? STEP_W'({LIM_W{1'b1}}) : STEP_W'(scaled[LIM_W-1:0]);
    sq_sum = {1'b0, sq_q} + {1'b0, mul_q[SQ_W-1:0]};
  end

  logic in_fire, out_free;
  assign in_fire  = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      out_valid_q     <= 1'b0;
      start_l_q       <= '0;
      start_r_q       <= '0;
      board_width_q   <= BOARD_WIDTH_RST;
      spu_q           <= SPU_RST;
      fast_reload_q   <= FAST_RELOAD_RST;
      base_interval_q <= BASE_INTERVAL_RST;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_BOARD_WIDTH:    board_width_q   <= cfg_data_i[COORD_W-1:0];
          CFG_STEPS_PER_UNIT: spu_q           <= cfg_data_i[SPU_W-1:0];
          CFG_FAST_RELOAD:    fast_reload_q   <= cfg_data_i[RELOAD_W-1:0];
          CFG_BASE_INTERVAL:  base_interval_q <= cfg_data_i[RELOAD_W-1:0];
          default: ;
        endcase
      end

      // load a new result, or drop the one just taken
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            kind_q  <= in_req_i.kind;
            x_q     <= in_req_i.x_coord;
            y_q     <= in_req_i.y_coord;
            side_q  <= 1'b0;
            sat_q   <= 1'b0;
            lr_q    <= '0;
            rr_q    <= '0;
            state_q <= S_SQX;
          end
        end
        S_SQX: begin
          mul_q   <= mul_p;
          state_q <= S_SQY;
        end
        S_SQY: begin
          sq_q    <= mul_q[SQ_W-1:0];
          mul_q   <= mul_p;
          state_q <= S_RAD;
        end
        S_RAD: begin
          rad_q   <= (2*ROOT_W)'(sq_sum) << (2 * SQRT_FRAC_BITS);
          rem_q   <= '0;
          root_q  <= '0;
          cnt_q   <= CNT_W'(ROOT_W - 1);
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          rem_q  <= sub_ge ? sub_diff : sub_cand;
          root_q <= {root_q[ROOT_W-2:0], sub_ge};
          rad_q  <= rad_q << 2;
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= S_SCALE;
          end
        end
        S_SCALE: begin
          mul_q   <= mul_p;
          state_q <= S_CLAMP;
        end
        S_CLAMP: begin
          if (over) begin
            sat_q <= 1'b1;
          end
          if (!side_q) begin
            lt_q    <= steps;
            side_q  <= 1'b1;
            state_q <= S_SQX;
          end else begin
            rt_q    <= steps;
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          dl_q    <= (lt_q > start_l_q) ? lt_q - start_l_q : start_l_q - lt_q;
          dr_q    <= (rt_q > start_r_q) ? rt_q - start_r_q : start_r_q - rt_q;
          state_q <= S_PICK;
        end
        S_PICK: begin
          if (!kind_q) begin
            start_l_q <= lt_q;
            start_r_q <= rt_q;
            state_q   <= S_DONE;
          end else if (dl_q == dr_q) begin
            lr_q    <= fast_reload_q;
            rr_q    <= fast_reload_q;
            state_q <= S_DONE;
          end else begin
            slow_left_q <= (dr_q > dl_q);
            long_q      <= (dr_q > dl_q) ? dr_q : dl_q;
            short_q     <= (dr_q > dl_q) ? dl_q : dr_q;
            if (dr_q > dl_q) begin
              rr_q <= fast_reload_q;
            end else begin
              lr_q <= fast_reload_q;
            end
            // shorter motor does not move: reload stays 0, flag it
            if (dl_q == '0 || dr_q == '0) begin
              sat_q   <= 1'b1;
              state_q <= S_DONE;
            end else begin
              state_q <= S_MULR;
            end
          end
        end
        S_MULR: begin
          mul_q   <= mul_p;
          state_q <= S_DLOAD;
        end
        S_DLOAD: begin
          div_q   <= mul_q[DIV_W-1:0];
          rem_q   <= '0;
          cnt_q   <= CNT_W'(DIV_W - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= sub_ge ? sub_diff : sub_cand;
          div_q <= {div_q[DIV_W-2:0], sub_ge};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= S_RFIN;
          end
        end
        S_RFIN: begin
          // quotient above 16 bits floors the reload at 0
          if (|div_q[DIV_W-1:RELOAD_W]) begin
            sat_q <= 1'b1;
          end else if (slow_left_q) begin
            lr_q <= ~div_q[RELOAD_W-1:0];
          end else begin
            rr_q <= ~div_q[RELOAD_W-1:0];
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_q.left_steps   <= lt_q;
            out_q.right_steps  <= rt_q;
            out_q.left_reload  <= lr_q;
            out_q.right_reload <= rr_q;
            out_q.reload_valid <= kind_q;
            out_q.saturated    <= sat_q;
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign cfg_ready_o = 1'b1;

endmodule
